// File: hdl/ir_pulse_distance_decoder_assert.svh
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder assertion macros
// concurrent checks that compile away when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define IPD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ipd check failed");
// next-cycle implication
`define IPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ipd check failed");
`else
`define IPD_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define IPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// types and constants shared by the pulse-distance decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

	localparam int CAP_W  = 16;
	localparam int CODE_W = 16;
	localparam int CNT_W  = 6;
	localparam int CIDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

	localparam logic [CAP_W-1:0] MIN_GAP_RST = 16'd500;
	localparam logic [CAP_W-1:0] MAX_GAP_RST = 16'd2500;
	localparam logic [CAP_W-1:0] ONE_THR_RST = 16'd1500;

	typedef enum logic [CIDX_W-1:0] {
		CFG_MIN_GAP = 2'd0,
		CFG_MAX_GAP = 2'd1,
		CFG_ONE_THR = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CAP_W-1:0] min_gap;
		logic [CAP_W-1:0] max_gap;
		logic [CAP_W-1:0] one_threshold;
	} cfg_t;

	typedef struct packed {
		logic in_range;
		logic bit_one;
	} gap_class_t;

endpackage

`default_nettype wire

// File: hdl/ipd_if.sv
// ----------------------------------------------------------------------------
// ipd_if
// valid/ready channels for capture timestamps and decoder results
// ----------------------------------------------------------------------------
`default_nettype none

interface ipd_capture_if
	import ipd_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capture_value;

	modport source(output valid, output capture_value, input ready);
	modport sink(input valid, input capture_value, output ready);
endinterface

interface ipd_result_if
	import ipd_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              frame_done;
	logic [CODE_W-1:0] last_code;
	logic [CNT_W-1:0]  bits_seen;

	modport source(output valid, output frame_done, output last_code, output bits_seen,
		input ready);
	modport sink(input valid, input frame_done, input last_code, input bits_seen,
		output ready);
endinterface

`default_nettype wire

// File: hdl/ipd_gap_classify.sv
// ----------------------------------------------------------------------------
// ipd_gap_classify
// gap between two timestamps of a down-counter, range check and bit decision
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_gap_classify
	import ipd_pkg::*;
(
	input  wire logic [CAP_W-1:0] prev_capture,
	input  wire logic [CAP_W-1:0] capture_value,
	input  wire cfg_t             cfg,
	output gap_class_t            cls
);

	logic [CAP_W-1:0] gap;

	// down-counter, so earlier minus later; one timer wrap falls out of the modulo
	assign gap = prev_capture - capture_value;

	always_comb begin
		cls.in_range = (gap >= cfg.min_gap) && (gap <= cfg.max_gap);
		cls.bit_one  = gap > cfg.one_threshold;
	end

endmodule

`default_nettype wire

// File: hdl/ipd_frame.sv
// ----------------------------------------------------------------------------
// ipd_frame
// frame state (last timestamp, shift register, bit counter, code) and result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_frame
	import ipd_pkg::*;
#(
	parameter int FRAME_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire logic [CAP_W-1:0] capture_s1,
	input  wire gap_class_t       cls,
	output logic [CAP_W-1:0]      prev_capture,
	output logic                  take,
	ipd_result_if.source          result
);

	logic [CAP_W-1:0]  prev_q;
	// only the low half of the 32-bit frame is ever latched, so only that is kept
	logic [CODE_W-1:0] shift_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CODE_W-1:0] code_q;
	logic              valid_q;
	logic              done_q;

	logic [CODE_W-1:0] shift_nxt;
	logic [CNT_W-1:0]  cnt_inc;

	assign take      = valid_s1 && (!valid_q || result.ready);
	assign shift_nxt = {shift_q[CODE_W-2:0], cls.bit_one};
	assign cnt_inc   = cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			shift_q <= '0;
			cnt_q   <= '0;
			code_q  <= '0;
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
				done_q  <= 1'b0;
				prev_q  <= capture_s1;
				if (!cls.in_range) begin
					cnt_q <= '0;
				end else begin
					shift_q <= shift_nxt;
					// counter holds at its top value
					if (cnt_q != CNT_MAX) begin
						cnt_q <= cnt_inc;
						if (cnt_inc == CNT_W'(FRAME_BITS)) begin
							code_q <= shift_nxt;
							done_q <= 1'b1;
						end
					end
				end
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign prev_capture      = prev_q;
	assign result.valid      = valid_q;
	assign result.frame_done = done_q;
	assign result.last_code  = code_q;
	assign result.bits_seen  = cnt_q;

endmodule

`default_nettype wire

// File: hdl/ir_pulse_distance_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Pulse-distance infrared decoder: takes one down-counter timestamp per
// falling edge of the receiver and returns one result per timestamp: the
// frame-complete flag, the latched 16-bit code and the saturating bit count.
// A timestamp enters an input register; its result is written to the result
// register when that register is empty or read, so one timestamp can be taken
// every cycle while results are read; the rate is set by the combinational
// update of gap, range check and bit counter against the stored frame state.
// Configuration writes (index 0 min gap, 1 max gap, 2 one threshold) are expected
// while no timestamp is in flight; other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_distance_decoder_assert.svh"

module ir_pulse_distance_decoder
	import ipd_pkg::*;
#(
	parameter int FRAME_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CAP_W-1:0]  cfg_data,
	ipd_capture_if.sink            capture,
	ipd_result_if.source           result
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [CAP_W-1:0] capture_s1;
	logic [CAP_W-1:0] prev_capture;
	logic             take;
	gap_class_t       cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_gap       <= MIN_GAP_RST;
			cfg_q.max_gap       <= MAX_GAP_RST;
			cfg_q.one_threshold <= ONE_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_GAP: cfg_q.min_gap       <= cfg_data;
				CFG_MAX_GAP: cfg_q.max_gap       <= cfg_data;
				CFG_ONE_THR: cfg_q.one_threshold <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	assign capture.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (capture.ready) begin
			valid_s1 <= capture.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (capture.valid && capture.ready) begin
			capture_s1 <= capture.capture_value;
		end
	end

	ipd_gap_classify u_classify (
		.prev_capture  (prev_capture),
		.capture_value (capture_s1),
		.cfg           (cfg_q),
		.cls           (cls)
	);

	ipd_frame #(
		.FRAME_BITS (FRAME_BITS)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.capture_s1   (capture_s1),
		.cls          (cls),
		.prev_capture (prev_capture),
		.take         (take),
		.result       (result)
	);

	`IPD_ASSERT_NOW(a_done_at_frame_len, clk, arst_n, result.valid && result.frame_done, result.bits_seen == CNT_W'(FRAME_BITS))
	`IPD_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, capture.valid && capture.ready, valid_s1)
	`IPD_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !capture.ready, valid_s1 && result.valid && !result.ready)
	`IPD_ASSERT_NEXT(a_count_moves_on_take, clk, arst_n, !take, $stable(result.bits_seen) && $stable(result.last_code))

endmodule

`default_nettype wire
